// File: rtl/core/grd_pkg.sv
package grd_pkg;

  localparam int LOG_FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

  localparam logic [4:0] FRAME_LEN = 5'd16;

  localparam logic [2:0] STATUS_OK    = 3'd0;
  localparam logic [2:0] STATUS_ADDR  = 3'd1;
  localparam logic [2:0] STATUS_DIGIT = 3'd2;
  localparam logic [2:0] STATUS_RANGE = 3'd3;
  localparam logic [2:0] STATUS_SHORT = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [13:0] mantissa;
    logic [6:0]  exp_digits;
  } grd_req_t;

endpackage

// File: rtl/core/gauge_reply_decoder.sv
// Decodes gauge reply frames presented one byte per request, and takes one byte every
// cycle while the verdict queue has room. On the byte marked frame_end the frame's
// checks are queued and one result follows: frames shorter than sixteen bytes, address
// mismatches, non-digit bytes and out-of-range values leave the back end straight from its
// idle state once they reach the head of the queue and the output is free. A frame with a
// valid pressure occupies the back end while the logarithm unit makes one fraction bit per
// cycle through a squaring multiplier and then scales the result over three more stages.
// The queue holds two verdicts, so byte input stalls only when verdicts arrive faster than
// the back end retires them.
module gauge_reply_decoder #(
  parameter int LOG_FRAC_BITS = grd_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               device_address_we,
  input  logic [9:0]         device_address_wdata,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_end,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         status,
  output logic signed [14:0] pressure_code
);
  import grd_pkg::*;

  grd_req_t req;
  grd_req_t head;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  grd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .addr_we    (device_address_we),
    .addr_wdata (device_address_wdata),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .rx_byte    (rx_byte),
    .frame_end  (frame_end),
    .push       (push),
    .req        (req),
    .q_full     (q_full)
  );

  grd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (req),
    .full  (q_full),
    .pop   (pop),
    .rdata (head),
    .empty (q_empty)
  );

  grd_back #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .pressure_code (pressure_code)
  );

endmodule

// File: rtl/core/grd_front.sv
module grd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              addr_we,
  input  logic [9:0]        addr_wdata,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic [7:0]        rx_byte,
  input  logic              frame_end,
  output logic              push,
  output grd_pkg::grd_req_t req,
  input  logic              q_full
);
  import grd_pkg::*;

  logic [3:0]  dig_hi;
  logic [3:0]  dig_mid;
  logic [3:0]  dig_lo;
  logic [4:0]  pos;
  logic        addr_ok;
  logic        digits_ok;
  logic [13:0] mantissa;
  logic [6:0]  exp_digits;

  logic [17:0] prod10;
  logic [15:0] prod100;
  logic [6:0]  q10;
  logic [3:0]  q100;
  logic [14:0] prod10b;
  logic [3:0]  q10_100;
  logic [6:0]  mid7;
  logic [9:0]  lo10;

  logic        accept;
  logic        is_digit;
  logic [3:0]  dval;
  logic [3:0]  dsel;
  logic [4:0]  pos_next;
  logic        addr_ok_next;
  logic        digits_ok_next;
  logic [13:0] mantissa_next;
  logic [6:0]  exp_digits_next;

  // Address digits come from multiplications by reciprocals of 10 and 100.
  assign prod10  = {8'b0, addr_wdata} * 18'd205;
  assign q10     = prod10[17:11];
  assign prod100 = {6'b0, addr_wdata} * 16'd41;
  assign q100    = prod100[15:12];
  assign prod10b = {8'b0, q10} * 15'd205;
  assign q10_100 = prod10b[14:11];
  assign mid7    = q10 - ({3'b0, q10_100} * 7'd10);
  assign lo10    = addr_wdata - ({3'b0, q10} * 10'd10);

  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;
  assign push       = accept && frame_end;

  assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign dval     = is_digit ? rx_byte[3:0] : 4'd0;

  always_comb begin
    if (pos == 5'd0) begin
      dsel = dig_hi;
    end else if (pos == 5'd1) begin
      dsel = dig_mid;
    end else begin
      dsel = dig_lo;
    end
  end

  always_comb begin
    addr_ok_next    = addr_ok;
    digits_ok_next  = digits_ok;
    mantissa_next   = mantissa;
    exp_digits_next = exp_digits;
    if (pos < 5'd3) begin
      if (rx_byte != {4'h3, dsel}) begin
        addr_ok_next = 1'b0;
      end
    end else if (pos >= 5'd10 && pos <= 5'd15) begin
      if (!is_digit) begin
        digits_ok_next = 1'b0;
      end
      if (pos <= 5'd13) begin
        mantissa_next = {mantissa[10:0], 3'b0} + {mantissa[12:0], 1'b0} + {10'b0, dval};
      end else begin
        exp_digits_next = {exp_digits[3:0], 3'b0} + {exp_digits[5:0], 1'b0} + {3'b0, dval};
      end
    end
    pos_next = (pos < FRAME_LEN) ? pos + 5'd1 : pos;
  end

  always_comb begin
    req.mantissa   = mantissa_next;
    req.exp_digits = exp_digits_next;
    if (pos_next < FRAME_LEN) begin
      req.status = STATUS_SHORT;
    end else if (!addr_ok_next) begin
      req.status = STATUS_ADDR;
    end else if (!digits_ok_next) begin
      req.status = STATUS_DIGIT;
    end else begin
      req.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dig_hi     <= 4'd0;
      dig_mid    <= 4'd0;
      dig_lo     <= 4'd2;
      pos        <= 5'd0;
      addr_ok    <= 1'b1;
      digits_ok  <= 1'b1;
      mantissa   <= 14'd0;
      exp_digits <= 7'd0;
    end else begin
      if (addr_we) begin
        dig_hi  <= q100;
        dig_mid <= mid7[3:0];
        dig_lo  <= lo10[3:0];
      end
      if (accept) begin
        if (frame_end) begin
          pos        <= 5'd0;
          addr_ok    <= 1'b1;
          digits_ok  <= 1'b1;
          mantissa   <= 14'd0;
          exp_digits <= 7'd0;
        end else begin
          pos        <= pos_next;
          addr_ok    <= addr_ok_next;
          digits_ok  <= digits_ok_next;
          mantissa   <= mantissa_next;
          exp_digits <= exp_digits_next;
        end
      end
    end
  end

endmodule

// File: rtl/core/grd_queue.sv
module grd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  grd_pkg::grd_req_t wdata,
  output logic              full,
  input  logic              pop,
  output grd_pkg::grd_req_t rdata,
  output logic              empty
);
  import grd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);

  grd_req_t      entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == COUNT_FULL);
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/grd_back.sv
module grd_back #(
  parameter int LOG_FRAC_BITS = grd_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  grd_pkg::grd_req_t head,
  input  logic              q_empty,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [2:0]        status,
  output logic signed [14:0] pressure_code
);
  import grd_pkg::*;

  localparam int LW   = LOG_FRAC_BITS + 4;
  localparam int PW   = LW + 31;
  localparam int QW   = LOG_FRAC_BITS + 3;
  localparam int KW   = QW + 10;
  localparam int TW   = LOG_FRAC_BITS + 20;
  localparam int CNTW = $clog2(LOG_FRAC_BITS + 1);
  localparam logic [CNTW-1:0] ITER_LAST = CNTW'(LOG_FRAC_BITS - 1);
  localparam logic [TW-1:0] BIAS =
    {{(TW - LOG_FRAC_BITS){1'b0}}, {LOG_FRAC_BITS{1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_ITER,
    S_MUL,
    S_SCALE,
    S_ADD,
    S_OUT
  } state_t;

  state_t                   state;
  logic [CNTW-1:0]          cnt;
  logic [30:0]              x;
  logic [LOG_FRAC_BITS-1:0] frac;
  logic [3:0]               n_r;
  logic signed [17:0]       c_r;
  logic [PW-1:0]            prod;
  logic [KW-1:0]            p1000;
  logic signed [TW-1:0]     t_r;

  logic [13:0]          m;
  logic signed [7:0]    e_val;
  logic signed [17:0]   e_wide;
  logic signed [17:0]   c0;
  logic [1:0]           k;
  logic signed [7:0]    p;
  logic                 pow10;
  logic                 range_ok;
  logic                 needs_log;
  logic                 out_free;
  logic                 emit;
  logic [3:0]           n0;
  logic [30:0]          x0;
  logic [61:0]          sq;
  logic [31:0]          sq_top;
  logic [PW-1:0]        prod_c;
  logic [QW-1:0]        lq;
  logic signed [TW-1:0] c_sh;
  logic signed [TW-1:0] t_c;
  logic signed [TW-1:0] tb;
  logic signed [TW-1:0] code_full;

  assign m      = head.mantissa;
  assign e_val  = $signed({1'b0, head.exp_digits}) - 8'sd18;
  assign e_wide = 18'(e_val);
  assign c0     = e_wide * 18'sd1000 + 18'sd500;

  always_comb begin
    if (m >= 14'd1000) begin
      k = 2'd3;
    end else if (m >= 14'd100) begin
      k = 2'd2;
    end else if (m >= 14'd10) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
  end

  assign pow10 = (m == 14'd1) || (m == 14'd10) || (m == 14'd100) || (m == 14'd1000);
  assign p     = e_val + $signed({6'b0, k}) - 8'sd3;
  assign range_ok = (m != 14'd0) && (p <= 8'sd9) &&
                    ((p > -8'sd10) || ((p == -8'sd10) && !pow10));

  always_comb begin
    n0 = 4'd0;
    for (int i = 0; i < 14; i++) begin
      if (m[i]) begin
        n0 = 4'(i);
      end
    end
  end

  assign x0 = {17'b0, m} << (5'd30 - {1'b0, n0});

  assign out_free  = !result_valid || !result_stall;
  assign needs_log = (head.status == STATUS_OK) && range_ok;
  assign pop       = (state == S_IDLE) && !q_empty && (needs_log || out_free);
  assign emit      = ((state == S_IDLE) && pop && !needs_log) ||
                     ((state == S_OUT) && out_free);

  assign sq     = x * x;
  assign sq_top = sq[61:30];

  assign prod_c = PW'({n_r, frac}) * PW'(LOG10_2_Q32);
  assign lq     = prod[PW-1:32];

  assign c_sh      = TW'(c_r) <<< LOG_FRAC_BITS;
  assign t_c       = $signed({7'b0, p1000}) + c_sh;
  assign tb        = t_r + (t_r[TW-1] ? $signed(BIAS) : $signed({TW{1'b0}}));
  assign code_full = tb >>> LOG_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      cnt           <= '0;
      status        <= STATUS_OK;
      pressure_code <= '0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (needs_log) begin
              x     <= x0;
              n_r   <= n0;
              c_r   <= c0;
              cnt   <= '0;
              state <= S_ITER;
            end else begin
              status        <= (head.status != STATUS_OK) ? head.status : STATUS_RANGE;
              pressure_code <= '0;
            end
          end
        end
        S_ITER: begin
          frac <= {frac[LOG_FRAC_BITS-2:0], sq_top[31]};
          x    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
          if (cnt == ITER_LAST) begin
            state <= S_MUL;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        S_MUL: begin
          prod  <= prod_c;
          state <= S_SCALE;
        end
        S_SCALE: begin
          p1000 <= KW'(lq) * KW'(1000);
          state <= S_ADD;
        end
        S_ADD: begin
          t_r   <= t_c;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            status        <= STATUS_OK;
            pressure_code <= code_full[14:0];
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
